@@ src/sso_pkg.sv @@
// Shared constants, register indexes and the sine table generator for the servo oscillator.
package sso_pkg;

    localparam int PHASE_BITS_DEF      = 16;
    localparam int TABLE_ADDR_BITS_DEF = 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int NOW_W       = 32;
    localparam int ANGLE_W     = 8;
    localparam int SINE_W      = 15;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SAMPLE_PERIOD = 3'd0,
        REG_PHASE_STEP    = 3'd1,
        REG_AMPLITUDE     = 3'd2,
        REG_OFFSET        = 3'd3,
        REG_PHASE_OFFSET  = 3'd4,
        REG_STOPPED       = 3'd5,
        REG_REVERSE       = 3'd6
    } cfg_reg_t;

    localparam logic [15:0]       SAMPLE_PERIOD_RST = 16'd30;
    localparam logic [15:0]       PHASE_STEP_RST    = 16'd993;
    localparam logic [6:0]        AMPLITUDE_RST     = 7'd45;
    localparam logic signed [7:0] OFFSET_RST        = 8'sd0;
    localparam logic [15:0]       PHASE_OFFSET_RST  = 16'd0;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;
    localparam int                 CENTER    = 90;

    localparam longint unsigned PIHALF_Q30 = 64'd1686629713;

    // Quarter-wave entry k: sin(pi/2 * k / 2^addr_bits) from a Q30 Taylor series,
    // rounded to Q0.15. Only evaluated at elaboration with constant arguments.
    function automatic logic [SINE_W-1:0] sine_q15(input int unsigned k,
                                                   input int unsigned addr_bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned v;
        x    = (PIHALF_Q30 * longint'(k)) >> addr_bits;
        x2   = (x * x) >> 30;
        sum  = longint'(x);
        term = ((x * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        v = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
        if (v > 32767)
        begin
            v = 32767;
        end
        return v[SINE_W-1:0];
    endfunction

endpackage

@@ src/servo_sine_oscillator.sv @@
// Sampled sine oscillator producing servo angles from millisecond time stamps.
//
//  channel | dir | signals                         | payload
//  --------+-----+---------------------------------+------------------------------
//  time in | in  | s_tvalid s_tready s_tdata[31:0] | now_ms
//  angle   | out | m_tvalid m_tready m_tdata[7:0]  | servo_angle (0..180)
//  config  | in  | cfg_valid cfg_ready             | cfg_index[2:0], cfg_data[15:0]
//
// A time word is taken every cycle while s_tready is high; the sample decision and
// phase update happen at acceptance; its angle goes via s1_phase_reg and out_angle_reg.
// The sine lookup, 7x15 multiply and saturation form the second stage.
// rst_n clears phase, last sample time and pipeline valids, and resets config to defaults.
// A stall on m_tready holds each full stage; s_tready drops only when both are full.
module servo_sine_oscillator #(
    parameter int PHASE_BITS      = sso_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = sso_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sso_pkg::NOW_W-1:0]       s_tdata,    // [31:0] now_ms
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sso_pkg::ANGLE_W-1:0]     m_tdata,    // [7:0] servo_angle
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sso_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sso_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sso_pkg::*;

    localparam int IDX_W = TABLE_ADDR_BITS + 2;
    localparam int TSW   = TABLE_ADDR_BITS + 1;
    localparam int QN    = 1 << TABLE_ADDR_BITS;

    // Configuration registers.
    logic [15:0]       sample_period_reg;
    logic [15:0]       phase_step_reg;
    logic [6:0]        amplitude_reg;
    logic signed [7:0] offset_reg;
    logic [15:0]       phase_offset_reg;
    logic              stopped_reg;
    logic              reverse_reg;

    logic [NOW_W-1:0]      last_sample_reg;
    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic                  s1_valid_reg;
    logic [PHASE_BITS-1:0] s1_phase_reg;
    logic                  out_valid_reg;
    logic [ANGLE_W-1:0]    out_angle_reg;

    logic                  out_free;
    logic                  s_fire;
    logic                  take_sample;
    logic                  emit;
    logic [NOW_W-1:0]      elapsed;
    logic [PHASE_BITS+15:0] step_wide;
    logic [PHASE_BITS+15:0] poff_wide;
    logic [PHASE_BITS-1:0] step_al;
    logic [PHASE_BITS-1:0] poff_al;

    logic [SINE_W-1:0]            qtab [0:QN];
    logic [PHASE_BITS+IDX_W-1:0]  ph_wide;
    logic [IDX_W-1:0]             tab_idx;
    logic [1:0]                   quad;
    logic [TABLE_ADDR_BITS-1:0]   r;
    logic [TSW-1:0]               tab_sel;
    logic [SINE_W-1:0]            t_abs;
    logic [21:0]                  prod;
    logic [22:0]                  prod_rnd;
    logic [7:0]                   mag;
    logic signed [9:0]            osc;
    logic signed [9:0]            pos;
    logic signed [9:0]            pos_c;
    logic [ANGLE_W-1:0]           angle_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg <= SAMPLE_PERIOD_RST;
            phase_step_reg    <= PHASE_STEP_RST;
            amplitude_reg     <= AMPLITUDE_RST;
            offset_reg        <= OFFSET_RST;
            phase_offset_reg  <= PHASE_OFFSET_RST;
            stopped_reg       <= 1'b0;
            reverse_reg       <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SAMPLE_PERIOD: sample_period_reg <= cfg_data;
                REG_PHASE_STEP:    phase_step_reg    <= cfg_data;
                REG_AMPLITUDE:     amplitude_reg     <= cfg_data[6:0];
                REG_OFFSET:        offset_reg        <= $signed(cfg_data[7:0]);
                REG_PHASE_OFFSET:  phase_offset_reg  <= cfg_data;
                REG_STOPPED:       stopped_reg       <= cfg_data[0];
                REG_REVERSE:       reverse_reg       <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Handshake and sample decision.
    assign out_free    = !out_valid_reg || m_tready;
    assign s_tready    = !s1_valid_reg || out_free;
    assign s_fire      = s_tvalid && s_tready;
    assign elapsed     = s_tdata - last_sample_reg;
    assign take_sample = elapsed > {16'd0, sample_period_reg};
    assign emit        = s_fire && take_sample && !stopped_reg;

    // Align the 16-bit phase registers to the accumulator width.
    assign step_wide = {phase_step_reg, {PHASE_BITS{1'b0}}};
    assign poff_wide = {phase_offset_reg, {PHASE_BITS{1'b0}}};
    assign step_al   = step_wide[PHASE_BITS+15:16];
    assign poff_al   = poff_wide[PHASE_BITS+15:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg <= '0;
            phase_acc_reg   <= '0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            if (s_fire && take_sample)
            begin
                last_sample_reg <= s_tdata;
            end
            if (emit)
            begin
                phase_acc_reg <= phase_acc_reg + step_al;
            end
            if (s_tready)
            begin
                s1_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s1_phase_reg <= phase_acc_reg + poff_al;
        end
    end

    // Quarter-wave table, folded to constants at elaboration.
    for (genvar k = 0; k <= QN; k++)
    begin : g_qtab
        assign qtab[k] = sine_q15(k, TABLE_ADDR_BITS);
    end

    always_comb
    begin
        ph_wide  = {s1_phase_reg, {IDX_W{1'b0}}};
        tab_idx  = ph_wide[PHASE_BITS+IDX_W-1:PHASE_BITS];
        quad     = tab_idx[IDX_W-1:TABLE_ADDR_BITS];
        r        = tab_idx[TABLE_ADDR_BITS-1:0];
        tab_sel  = quad[0] ? (TSW'(QN) - {1'b0, r}) : {1'b0, r};
        t_abs    = qtab[tab_sel];
        prod     = 22'(amplitude_reg) * 22'(t_abs);
        prod_rnd = {1'b0, prod} + 23'd16384;
        mag      = prod_rnd[22:15];
        // The second half of the wave is the negative lobe.
        osc      = quad[1] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        pos      = osc + 10'(offset_reg);
        if (reverse_reg)
        begin
            pos = -pos;
        end
        pos_c = pos + 10'sd90;
        if (pos_c < 0)
        begin
            angle_next = '0;
        end
        else if (pos_c > $signed({2'b00, ANGLE_MAX}))
        begin
            angle_next = ANGLE_MAX;
        end
        else
        begin
            angle_next = pos_c[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            out_angle_reg <= angle_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_angle_reg;

    // The input side stalls only when both stages hold a word and the output is blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full blocked pipeline");

    // The phase moves only on a sample that produces an angle.
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !emit |=> $stable(phase_acc_reg))
        else $error("phase accumulator changed without an emitted sample");

    // A first-stage word moves into a free output register.
    a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_free) |=> out_valid_reg)
        else $error("first-stage word lost");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_angle_reg <= ANGLE_MAX))
        else $error("servo angle out of range");

endmodule
